/* hdl/tcdv_pkg.sv */
// Package for the triangle circumcentric dual measures pipeline.
// Holds fixed widths, derived arithmetic widths and the request structs.
// No dependencies.
package tcdv_pkg;

  // Coordinate format and world dimension
  localparam int COORD_WIDTH = 24;
  localparam int WORLD_DIM   = 3;

  // Low bits dropped from edge components on wide coordinates
  localparam int PRESHIFT = (COORD_WIDTH > 28) ? COORD_WIDTH - 28 : 0;

  // Derived arithmetic widths
  localparam int EW  = COORD_WIDTH + 1 - PRESHIFT; // signed edge component
  localparam int SQW = 2 * EW;                     // squared lengths, |dot|, |cross|
  localparam int GW  = 4 * EW;                     // Gram determinant
  localparam int RW  = GW / 2;                     // sqrt result
  localparam int NW  = 3 * EW;                     // dividend and quotient
  localparam int DVW = 2 * EW + 1;                 // divisor 2*D
  localparam int PW  = 4 * EW;                     // dual * length product

  // Output formats
  localparam int LEN_W      = 32;
  localparam int AREA_W     = 48;
  localparam int AREA_SHIFT = 18 - 2 * PRESHIFT;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
  } corner_t;

  typedef struct packed {
    logic [LEN_W-1:0]  edge_len_0;
    logic [LEN_W-1:0]  edge_len_1;
    logic [LEN_W-1:0]  edge_len_2;
    logic [LEN_W-1:0]  dual_len_0;
    logic [LEN_W-1:0]  dual_len_1;
    logic [LEN_W-1:0]  dual_len_2;
    logic [AREA_W-1:0] dual_area_0;
    logic [AREA_W-1:0] dual_area_1;
    logic [AREA_W-1:0] dual_area_2;
    logic              degenerate;
  } meas_t;

endpackage

/* hdl/tcdv_delay.sv */
// Valid and sideband delay line that tracks the latency of a pipelined unit.
// Standalone; no package needed.
module tcdv_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_in,
  input  logic [W-1:0] data_in,
  output logic         vld_out,
  output logic [W-1:0] data_out
);

  logic         vld_q [N];
  logic [W-1:0] dat_q [N];

  // Valid chain, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld_in;
      for (int i = 1; i < N; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Sideband chain
  always_ff @(posedge clk) begin
    if (en) begin
      dat_q[0] <= data_in;
      for (int i = 1; i < N; i++) dat_q[i] <= dat_q[i-1];
    end
  end

  assign vld_out  = vld_q[N-1];
  assign data_out = dat_q[N-1];

endmodule

/* hdl/tcdv_sqrt.sv */
// Pipelined integer square root, one result bit per stage (digit recurrence).
// Standalone.
module tcdv_sqrt #(
  parameter int IW = 100
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   rad,
  output logic [IW/2-1:0] root
);

  localparam int OW = IW / 2;

  logic [IW-1:0] rad_q  [OW];
  logic [OW+1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];

  for (genvar i = 0; i < OW; i++) begin : g_stage
    logic [IW-1:0] rad_in;
    logic [OW+1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [OW+3:0] rem_sh;
    logic [OW+1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // Bring down the next two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in, rad_in[IW-1-2*i -: 2]};
      trial  = {root_in, 2'b01};
      ge     = rem_sh >= (OW+4)'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= rad_in;
        rem_q[i]  <= ge ? (OW+2)'(rem_sh - (OW+4)'(trial)) : (OW+2)'(rem_sh);
        root_q[i] <= {root_in[OW-2:0], ge};
      end
    end
  end

  assign root = root_q[OW-1];

endmodule

/* hdl/tcdv_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Standalone. A zero divisor gives an all-ones quotient.
module tcdv_div #(
  parameter int NW = 75,
  parameter int DW = 51
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (i == 0) begin : g_first
      assign num_in = num;
      assign den_in = den;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      rem_sh = {rem_in, num_in[NW-1-i]};
      ge     = rem_sh >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[i] <= num_in;
        den_q[i] <= den_in;
        rem_q[i] <= ge ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
        quo_q[i] <= {quo_in[NW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[NW-1];

endmodule

/* hdl/triangle_circumcentric_dual_volumes.sv */
// Top level: circumcentric dual lengths and Voronoi vertex areas of a triangle.
// Uses tcdv_pkg, tcdv_sqrt, tcdv_div and tcdv_delay.
//
//   channel   valid          stall          payload
//   request   corner_valid   corner_stall   corners (corner_t)
//   result    meas_valid     meas_stall     meas    (meas_t)
//
// One triangle enters per cycle unless the result side stalls; most of the
// pipeline depth comes from the bit-per-stage square root and divider pipelines.
// Reset is synchronous and clears only the valid bits of every stage.
// A stall on the result side freezes the whole pipeline in place and is
// passed straight back as corner_stall; nothing is dropped or repeated.
module triangle_circumcentric_dual_volumes
  import tcdv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    corner_valid,
  output logic    corner_stall,
  input  corner_t corners,
  output logic    meas_valid,
  input  logic    meas_stall,
  output meas_t   meas
);

  localparam int CW  = COORD_WIDTH;
  localparam int LSW = EW + PRESHIFT + LEN_W;
  localparam int DSW = NW + PRESHIFT + LEN_W;
  localparam int ASW = PW + 1 + AREA_W;

  logic en;
  assign en           = !(meas_valid && meas_stall);
  assign corner_stall = !en;

  // Corner unpack; z is dropped in a planar world
  logic signed [CW-1:0] pt [3][3];
  assign pt[0][0] = corners.p0_x;
  assign pt[0][1] = corners.p0_y;
  assign pt[0][2] = (WORLD_DIM > 2) ? corners.p0_z : '0;
  assign pt[1][0] = corners.p1_x;
  assign pt[1][1] = corners.p1_y;
  assign pt[1][2] = (WORLD_DIM > 2) ? corners.p1_z : '0;
  assign pt[2][0] = corners.p2_x;
  assign pt[2][1] = corners.p2_y;
  assign pt[2][2] = (WORLD_DIM > 2) ? corners.p2_z : '0;

  // Stage 1: edge vectors, e_k = p[k+2] - p[k+1], floor pre-shift
  logic signed [EW-1:0] evec_next [3][3];
  logic signed [EW-1:0] evec_s1   [3][3];
  logic                 v1;

  always_comb begin
    logic signed [CW:0] diff;
    diff = '0;
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        diff = (CW+1)'(pt[(k+2)%3][d]) - (CW+1)'(pt[(k+1)%3][d]);
        evec_next[k][d] = EW'(diff >>> PRESHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) evec_s1 <= evec_next;
  end

  // Stage 2: all component products
  logic signed [SQW-1:0] sq_s2 [3][3];
  logic signed [SQW-1:0] dp_s2 [3][3];
  logic signed [SQW-1:0] cr_s2 [3][2];
  logic                  v2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int d = 0; d < 3; d++) begin
          sq_s2[k][d] <= evec_s1[k][d] * evec_s1[k][d];
          dp_s2[k][d] <= evec_s1[(k+1)%3][d] * evec_s1[(k+2)%3][d];
        end
        // cross product e1 x e2
        cr_s2[k][0] <= evec_s1[1][(k+1)%3] * evec_s1[2][(k+2)%3];
        cr_s2[k][1] <= evec_s1[1][(k+2)%3] * evec_s1[2][(k+1)%3];
      end
    end
  end

  // Stage 3: squared lengths, dot products, cross components
  logic [SQW-1:0]      s_s3 [3];
  logic signed [SQW:0] c_s3 [3];
  logic signed [SQW:0] q_s3 [3];
  logic                v3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s_s3[k] <= SQW'(sq_s2[k][0] + sq_s2[k][1] + sq_s2[k][2]);
        c_s3[k] <= (SQW+1)'(dp_s2[k][0]) + (SQW+1)'(dp_s2[k][1])
                   + (SQW+1)'(dp_s2[k][2]);
        q_s3[k] <= (SQW+1)'(cr_s2[k][0]) - (SQW+1)'(cr_s2[k][1]);
      end
    end
  end

  // Stage 4: magnitudes, cross components squared as half-width partials
  logic [SQW-1:0] qmag [3];
  logic [SQW-1:0] cmag [3];
  logic [SQW-1:0] aa_s4 [3];
  logic [SQW-1:0] ab_s4 [3];
  logic [SQW-1:0] bb_s4 [3];
  logic [SQW-1:0] s_s4  [3];
  logic [SQW-1:0] c_s4  [3];
  logic           v4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qmag[k] = q_s3[k][SQW] ? SQW'(-q_s3[k]) : SQW'(q_s3[k]);
      cmag[k] = c_s3[k][SQW] ? SQW'(-c_s3[k]) : SQW'(c_s3[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        aa_s4[k] <= qmag[k][SQW-1:EW] * qmag[k][SQW-1:EW];
        ab_s4[k] <= qmag[k][SQW-1:EW] * qmag[k][EW-1:0];
        bb_s4[k] <= qmag[k][EW-1:0] * qmag[k][EW-1:0];
        s_s4[k]  <= s_s3[k];
        c_s4[k]  <= cmag[k];
      end
    end
  end

  // Stage 5: combine partials into q^2
  logic [GW-1:0]  qsq_s5 [3];
  logic [SQW-1:0] s_s5   [3];
  logic [SQW-1:0] c_s5   [3];
  logic           v5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        qsq_s5[k] <= (GW'(aa_s4[k]) << (2*EW)) + (GW'(ab_s4[k]) << (EW+1))
                     + GW'(bb_s4[k]);
        s_s5[k]   <= s_s4[k];
        c_s5[k]   <= c_s4[k];
      end
    end
  end

  // Stage 6: Gram determinant
  logic [GW-1:0]  g_s6;
  logic [SQW-1:0] s_s6 [3];
  logic [SQW-1:0] c_s6 [3];
  logic           v6;

  always_ff @(posedge clk) begin
    if (en) begin
      g_s6 <= qsq_s5[0] + qsq_s5[1] + qsq_s5[2];
      s_s6 <= s_s5;
      c_s6 <= c_s5;
    end
  end

  // Square roots: D from G, L_k from squared lengths
  logic [RW-1:0]    droot;
  logic [RW-1:0]    lroot [3];
  logic [3*SQW-1:0] cside_in;
  logic [3*SQW-1:0] cside_out;
  logic             vsq;

  tcdv_sqrt #(.IW(GW)) u_sqrt_d (
    .clk  (clk),
    .en   (en),
    .rad  (g_s6),
    .root (droot)
  );

  for (genvar k = 0; k < 3; k++) begin : g_sqrt_l
    tcdv_sqrt #(.IW(GW)) u_sqrt_l (
      .clk  (clk),
      .en   (en),
      .rad  (GW'(s_s6[k])),
      .root (lroot[k])
    );
    assign cside_in[k*SQW +: SQW] = c_s6[k];
  end

  tcdv_delay #(.W(3*SQW), .N(RW)) u_dly_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (v6),
    .data_in  (cside_in),
    .vld_out  (vsq),
    .data_out (cside_out)
  );

  // Stage 7: L * |c| as two half-width partials
  logic [SQW-1:0] ml_s7 [3];
  logic [SQW-1:0] mh_s7 [3];
  logic [EW-1:0]  l_s7  [3];
  logic [RW-1:0]  d_s7;
  logic           v7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ml_s7[k] <= lroot[k][EW-1:0] * cside_out[k*SQW +: EW];
        mh_s7[k] <= lroot[k][EW-1:0] * cside_out[k*SQW+EW +: EW];
        l_s7[k]  <= lroot[k][EW-1:0];
      end
      d_s7 <= droot;
    end
  end

  // Stage 8: dividend, divisor 2*D, degenerate flag
  logic [NW-1:0]  num_s8 [3];
  logic [DVW-1:0] den_s8;
  logic [EW-1:0]  l_s8   [3];
  logic           deg_s8;
  logic           v8;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_s8[k] <= NW'(ml_s7[k]) + (NW'(mh_s7[k]) << EW);
        l_s8[k]   <= l_s7[k];
      end
      den_s8 <= {d_s7, 1'b0};
      deg_s8 <= (d_s7 == '0);
    end
  end

  // Dividers: dual_k = L_k * |c_k| / (2D)
  logic [NW-1:0]     quo [3];
  logic [3*EW:0]     lside_in;
  logic [3*EW:0]     lside_out;
  logic              vdv;

  for (genvar k = 0; k < 3; k++) begin : g_div
    tcdv_div #(.NW(NW), .DW(DVW)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_s8[k]),
      .den (den_s8),
      .quo (quo[k])
    );
    assign lside_in[k*EW +: EW] = l_s8[k];
  end
  assign lside_in[3*EW] = deg_s8;

  tcdv_delay #(.W(3*EW+1), .N(NW)) u_dly_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (v8),
    .data_in  (lside_in),
    .vld_out  (vdv),
    .data_out (lside_out)
  );

  // Stage 9: dual * L in three partials
  logic [SQW-1:0] pp_s9   [3][3];
  logic [NW-1:0]  dual_s9 [3];
  logic [EW-1:0]  l_s9    [3];
  logic           deg_s9;
  logic           v9;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pp_s9[k][j] <= quo[k][j*EW +: EW] * lside_out[k*EW +: EW];
        end
        dual_s9[k] <= quo[k];
        l_s9[k]    <= lside_out[k*EW +: EW];
      end
      deg_s9 <= lside_out[3*EW];
    end
  end

  // Stage 10: combine products
  logic [PW-1:0] prod_s10 [3];
  logic [NW-1:0] dual_s10 [3];
  logic [EW-1:0] l_s10    [3];
  logic          deg_s10;
  logic          v10;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_s10[k] <= PW'(pp_s9[k][0]) + (PW'(pp_s9[k][1]) << EW)
                       + (PW'(pp_s9[k][2]) << (2*EW));
        dual_s10[k] <= dual_s9[k];
        l_s10[k]    <= l_s9[k];
      end
      deg_s10 <= deg_s9;
    end
  end

  // Stage 11: scale, saturate, zero on degenerate
  logic [LSW-1:0]    lwide [3];
  logic [DSW-1:0]    dwide [3];
  logic [ASW-1:0]    awide [3];
  logic [LEN_W-1:0]  lsat  [3];
  logic [LEN_W-1:0]  dsat  [3];
  logic [AREA_W-1:0] asat  [3];
  meas_t             meas_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lwide[k] = LSW'(l_s10[k]) << PRESHIFT;
      dwide[k] = DSW'(dual_s10[k]) << PRESHIFT;
      awide[k] = (ASW'(prod_s10[(k+1)%3]) + ASW'(prod_s10[(k+2)%3])) >> AREA_SHIFT;
      lsat[k]  = (|lwide[k][LSW-1:LEN_W]) ? '1 : lwide[k][LEN_W-1:0];
      dsat[k]  = (|dwide[k][DSW-1:LEN_W]) ? '1 : dwide[k][LEN_W-1:0];
      asat[k]  = (|awide[k][ASW-1:AREA_W]) ? '1 : awide[k][AREA_W-1:0];
      if (deg_s10) begin
        lsat[k] = '0;
        dsat[k] = '0;
        asat[k] = '0;
      end
    end
    meas_next.edge_len_0  = lsat[0];
    meas_next.edge_len_1  = lsat[1];
    meas_next.edge_len_2  = lsat[2];
    meas_next.dual_len_0  = dsat[0];
    meas_next.dual_len_1  = dsat[1];
    meas_next.dual_len_2  = dsat[2];
    meas_next.dual_area_0 = asat[0];
    meas_next.dual_area_1 = asat[1];
    meas_next.dual_area_2 = asat[2];
    meas_next.degenerate  = deg_s10;
  end

  always_ff @(posedge clk) begin
    if (en) meas <= meas_next;
  end

  // Valid bits of the local stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      v5         <= 1'b0;
      v6         <= 1'b0;
      v7         <= 1'b0;
      v8         <= 1'b0;
      v9         <= 1'b0;
      v10        <= 1'b0;
      meas_valid <= 1'b0;
    end else if (en) begin
      v1         <= corner_valid;
      v2         <= v1;
      v3         <= v2;
      v4         <= v3;
      v5         <= v4;
      v6         <= v5;
      v7         <= vsq;
      v8         <= v7;
      v9         <= vdv;
      v10        <= v9;
      meas_valid <= v10;
    end
  end

endmodule

/* hdl/tcdv_checker.sv */
// Port-level checker for triangle_circumcentric_dual_volumes, bound to the top.
// Uses tcdv_pkg for the result struct.
module tcdv_checker
  import tcdv_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  corner_valid,
  input logic  corner_stall,
  input logic  meas_valid,
  input logic  meas_stall,
  input meas_t meas
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas_stall |=> meas_valid && $stable(meas))
    else $error("stalled result changed");

  // Back-pressure on requests only comes from a stalled result
  a_bp: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_stall |-> meas_valid && meas_stall)
    else $error("request stalled without result stall");

  // Reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !meas_valid)
    else $error("result valid right after reset");

  // Degenerate triangles report zero edge lengths and dual areas
  a_deg: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas.degenerate |->
      meas.edge_len_0 == 0 && meas.edge_len_1 == 0 && meas.edge_len_2 == 0 &&
      meas.dual_area_0 == 0 && meas.dual_area_1 == 0 && meas.dual_area_2 == 0)
    else $error("degenerate result with nonzero measures");

  // A proper triangle has three nonzero edges
  a_edges: assert property (@(posedge clk) disable iff (rst)
    meas_valid && !meas.degenerate |->
      meas.edge_len_0 != 0 && meas.edge_len_1 != 0 && meas.edge_len_2 != 0)
    else $error("zero edge on non-degenerate triangle");

endmodule

bind triangle_circumcentric_dual_volumes tcdv_checker u_tcdv_checker (
  .clk          (clk),
  .rst          (rst),
  .corner_valid (corner_valid),
  .corner_stall (corner_stall),
  .meas_valid   (meas_valid),
  .meas_stall   (meas_stall),
  .meas         (meas)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for triangle_circumcentric_dual_volumes: streams triangles,
// predicts lengths, dual lengths and vertex areas in 128-bit integer math.
// Depends on tcdv_pkg and the block's RTL.
module tb_top;
  import tcdv_pkg::*;

  localparam int PAUSE_AT = 300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    corner_valid = 1'b0;
  logic    corner_stall;
  corner_t corners = '0;
  logic    meas_valid;
  logic    meas_stall = 1'b0;
  meas_t   meas;

  corner_t tri_q[$];
  meas_t   meas_q[$];
  int      n_sent = 0;
  int      n_bad = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      cyc = 0;

  triangle_circumcentric_dual_volumes dut (
    .clk(clk), .rst(rst),
    .corner_valid(corner_valid), .corner_stall(corner_stall), .corners(corners),
    .meas_valid(meas_valid), .meas_stall(meas_stall), .meas(meas)
  );

  always #2 clk = ~clk;

  // Floor integer square root of a 128-bit value
  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] sat(logic [127:0] v, int w);
    logic [127:0] mx;
    mx = (128'd1 << w) - 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic logic [127:0] mag(longint v);
    logic [127:0] r;
    r = 128'((v < 0) ? -v : v);
    return r;
  endfunction

  // Expected measures of one triangle
  function automatic meas_t tri_measures(corner_t c);
    longint p[3][3], e[3][3], dt[3], cr[3];
    logic [127:0] g, d, len[3], dual[3], prod[3], area;
    meas_t m;
    p[0][0] = $signed(c.p0_x); p[0][1] = $signed(c.p0_y); p[0][2] = $signed(c.p0_z);
    p[1][0] = $signed(c.p1_x); p[1][1] = $signed(c.p1_y); p[1][2] = $signed(c.p1_z);
    p[2][0] = $signed(c.p2_x); p[2][1] = $signed(c.p2_y); p[2][2] = $signed(c.p2_z);
    if (WORLD_DIM < 3) begin
      for (int v = 0; v < 3; v++) p[v][2] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      e[0][k] = (p[2][k] - p[1][k]) >>> PRESHIFT;
      e[1][k] = (p[0][k] - p[2][k]) >>> PRESHIFT;
      e[2][k] = (p[1][k] - p[0][k]) >>> PRESHIFT;
    end
    for (int k = 0; k < 3; k++) begin
      dt[k] = e[(k+1)%3][0] * e[(k+2)%3][0] + e[(k+1)%3][1] * e[(k+2)%3][1]
            + e[(k+1)%3][2] * e[(k+2)%3][2];
    end
    cr[0] = e[1][1] * e[2][2] - e[1][2] * e[2][1];
    cr[1] = e[1][2] * e[2][0] - e[1][0] * e[2][2];
    cr[2] = e[1][0] * e[2][1] - e[1][1] * e[2][0];
    g = mag(cr[0]) * mag(cr[0]) + mag(cr[1]) * mag(cr[1]) + mag(cr[2]) * mag(cr[2]);
    m = '0;
    if (g == 0) begin
      m.degenerate = 1'b1;
      return m;
    end
    d = isqrt(g);
    for (int k = 0; k < 3; k++) begin
      len[k]  = isqrt(mag(e[k][0] * e[k][0] + e[k][1] * e[k][1] + e[k][2] * e[k][2]));
      dual[k] = (len[k] * mag(dt[k])) / (2 * d);
      prod[k] = dual[k] * len[k];
    end
    m.edge_len_0 = LEN_W'(sat(len[0] << PRESHIFT, LEN_W));
    m.edge_len_1 = LEN_W'(sat(len[1] << PRESHIFT, LEN_W));
    m.edge_len_2 = LEN_W'(sat(len[2] << PRESHIFT, LEN_W));
    m.dual_len_0 = LEN_W'(sat(dual[0] << PRESHIFT, LEN_W));
    m.dual_len_1 = LEN_W'(sat(dual[1] << PRESHIFT, LEN_W));
    m.dual_len_2 = LEN_W'(sat(dual[2] << PRESHIFT, LEN_W));
    area = (prod[1] + prod[2]) >> AREA_SHIFT;
    m.dual_area_0 = AREA_W'(sat(area, AREA_W));
    area = (prod[2] + prod[0]) >> AREA_SHIFT;
    m.dual_area_1 = AREA_W'(sat(area, AREA_W));
    area = (prod[0] + prod[1]) >> AREA_SHIFT;
    m.dual_area_2 = AREA_W'(sat(area, AREA_W));
    m.degenerate = 1'b0;
    return m;
  endfunction

  task automatic add_tri(longint ax, ay, az, bx, by, bz, cx, cy, cz);
    corner_t c;
    c.p0_x = COORD_WIDTH'(ax); c.p0_y = COORD_WIDTH'(ay); c.p0_z = COORD_WIDTH'(az);
    c.p1_x = COORD_WIDTH'(bx); c.p1_y = COORD_WIDTH'(by); c.p1_z = COORD_WIDTH'(bz);
    c.p2_x = COORD_WIDTH'(cx); c.p2_y = COORD_WIDTH'(cy); c.p2_z = COORD_WIDTH'(cz);
    tri_q.push_back(c);
  endtask

  function automatic longint srand(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  // Request driver: bursts and gaps, one drain pause partway through
  always @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
    end else if (!corner_valid || !corner_stall) begin
      if (corner_valid) meas_q.push_back(tri_measures(corners));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        corner_valid <= 1'b0;
      end else if (tri_q.size() == 0 ||
                   (n_sent == PAUSE_AT && (meas_q.size() != 0 || corner_valid))) begin
        corner_valid <= 1'b0;
      end else begin
        corner_valid <= 1'b1;
        corners <= tri_q.pop_front();
        n_sent <= n_sent + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result stall pattern: free-running, random, then long stretches
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      meas_stall <= 1'b0;
    end else begin
      case ((cyc / 700) % 3)
        0: meas_stall <= 1'b0;
        1: meas_stall <= ($urandom_range(9) < 3);
        default: meas_stall <= ((cyc % 23) < 9);
      endcase
    end
  end

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    meas_t x;
    if (!rst && meas_valid && !meas_stall) begin
      if (meas_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", meas);
      end else begin
        x = meas_q.pop_front();
        check_field("edge_len_0", 48'(x.edge_len_0), 48'(meas.edge_len_0));
        check_field("edge_len_1", 48'(x.edge_len_1), 48'(meas.edge_len_1));
        check_field("edge_len_2", 48'(x.edge_len_2), 48'(meas.edge_len_2));
        check_field("dual_len_0", 48'(x.dual_len_0), 48'(meas.dual_len_0));
        check_field("dual_len_1", 48'(x.dual_len_1), 48'(meas.dual_len_1));
        check_field("dual_len_2", 48'(x.dual_len_2), 48'(meas.dual_len_2));
        check_field("dual_area_0", x.dual_area_0, meas.dual_area_0);
        check_field("dual_area_1", x.dual_area_1, meas.dual_area_1);
        check_field("dual_area_2", x.dual_area_2, meas.dual_area_2);
        check_field("degenerate", 48'(x.degenerate), 48'(meas.degenerate));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    longint mx, mn, u, ox, oy, oz, dx, dy, dz;
    int k, s;
    mx = 64'sd8388607;
    mn = -64'sd8388608;
    u = 64'sd65536;
    // directed: degenerate cases, extremes, saturation, common shapes
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_tri(0, 0, 0, u, u, 0, 2*u, 2*u, 0);
    add_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0);
    add_tri(0, 0, 0, u, 0, 0, 0, u, 0);
    add_tri(0, 0, 0, 2*u, 0, 0, u, 113512, 0);
    add_tri(mn, mn, 0, mx, mn, 0, mn, mx, 0);
    add_tri(mn, mn, mn, mx, mn, mx, mn, mx, mx);
    add_tri(mn, 0, 0, mx, 0, 0, 0, 1, 0);
    add_tri(mn, mn, mn, mx, mx, mx, mx, mx, mx - 1);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx);
    add_tri(mn, 0, 0, 0, mn, 0, 0, 0, mn);
    add_tri(0, 0, 0, 10*u, 0, 0, 5*u, 1, 0);
    add_tri(-u, -u, -u, u, u, u, -u, u, -u);
    add_tri(mx, mn, mx, mn, mx, mn, 0, 0, 0);
    add_tri(3*u, 5*u, 0, 3*u, 5*u, 0, 7*u, 1, 2);
    add_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1);
    add_tri(mx, mx, 0, mn, mn, 0, mx, mn, 0);
    // random: mostly well-formed shapes, some extreme noise
    for (int i = 0; i < 530; i++) begin
      k = int'($urandom_range(6));
      ox = srand(4194304); oy = srand(4194304); oz = srand(4194304);
      s = 1 << $urandom_range(21, 4);
      case (k)
        0: add_tri(srand(8388607), srand(8388607), srand(8388607),
                   srand(8388607), srand(8388607), srand(8388607),
                   srand(8388607), srand(8388607), srand(8388607));
        1: add_tri(ox, oy, oz, ox + srand(s), oy + srand(s), oz + srand(s),
                   ox + srand(s), oy + srand(s), oz + srand(s));
        2: add_tri(ox, oy, 0, ox + srand(s), oy + srand(s), 0,
                   ox + srand(s), oy + srand(s), 0);
        3: begin
          dx = srand(s / 4); dy = srand(s / 4); dz = srand(s / 4);
          add_tri(ox, oy, oz, ox + dx, oy + dy, oz + dz,
                  ox + 3 * dx, oy + 3 * dy, oz + 3 * dz);
        end
        4: begin
          dx = srand(s); dy = srand(s);
          add_tri(ox, oy, oz, ox + dx, oy + dy, oz,
                  ox + 2 * dx + srand(3), oy + 2 * dy + srand(3), oz + srand(3));
        end
        5: add_tri(ox, oy, oz, ox, oy, oz, ox + srand(s), oy + srand(s), oz + srand(s));
        default: add_tri(($urandom_range(1) ? mx : mn), ($urandom_range(1) ? mx : mn),
                         ($urandom_range(1) ? mx : mn), ($urandom_range(1) ? mx : mn),
                         ($urandom_range(1) ? mx : mn), ($urandom_range(1) ? mx : mn),
                         srand(8388607), srand(8388607), srand(8388607));
      endcase
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (tri_q.size() == 0 && !corner_valid && meas_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
